// ===== src/skf_pkg.sv =====
package skf_pkg;

  // Default fraction width of the internal variance, gain and estimate formats.
  localparam int FRAC_BITS_DEF = 16;

  // Configuration port geometry.
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEAS_NOISE = 2'd0,
    CFG_PROC_NOISE = 2'd1,
    CFG_INIT_EST   = 2'd2,
    CFG_INIT_EV    = 2'd3
  } cfg_idx_t;

  // Register values after reset.
  localparam logic [19:0] MEAS_NOISE_RST = 20'd32768;
  localparam logic [19:0] PROC_NOISE_RST = 20'd655;
  localparam logic [15:0] INIT_EST_RST   = 16'd2509;
  localparam logic [19:0] INIT_EV_RST    = 20'd65536;

  // Sequencer strobes that drive the divider and the multiply lanes.
  typedef struct packed {
    logic start;     // load operands, clear accumulators
    logic div_step;  // produce one quotient bit
    logic mac_step;  // fold the previous quotient bit into the products
  } skf_ctl_t;

  // Rescale a Q4.16 register value to Q4.f.
  function automatic logic [43:0] var_scale(input logic [19:0] v, input int f);
    logic [43:0] r;
    if (f >= 16) begin
      r = 44'(v) << (f - 16);
    end else begin
      r = 44'(v) >> (16 - f);
    end
    return r;
  endfunction

  // Rescale a Q1.f gain to Q1.16.
  function automatic logic [16:0] gain_scale(input logic [24:0] k, input int f);
    logic [40:0] r;
    if (f >= 16) begin
      r = 41'(k) >> (f - 16);
    end else begin
      r = 41'(k) << (16 - f);
    end
    return r[16:0];
  endfunction

endpackage

// ===== src/skf_div.sv =====
// Restoring divider that yields one quotient bit per step, most significant
// bit first. The quotient is floor(p1 * 2^F / den), which never exceeds 2^F.
module skf_div #(
  parameter int VW = 20
) (
  input  logic             clk,
  input  skf_pkg::skf_ctl_t ctl,
  input  logic [VW-1:0]    p1,
  input  logic [VW-1:0]    meas_var,
  output logic             qbit
);
  import skf_pkg::*;

  logic [VW:0]   rem;
  logic [VW:0]   den;
  logic          first;
  logic [VW+1:0] trial;
  logic          ge;

  // The first step compares the plain remainder, later steps the doubled one.
  always_comb begin
    trial = first ? {1'b0, rem} : {rem, 1'b0};
    ge    = trial >= {1'b0, den};
  end

  // Remainder register; a zero divisor forces every quotient bit to zero.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem   <= {1'b0, p1};
      den   <= {1'b0, p1} + {1'b0, meas_var};
      first <= 1'b1;
      qbit  <= 1'b0;
    end else if (ctl.div_step) begin
      rem   <= ge ? (VW+1)'(trial - {1'b0, den}) : (VW+1)'(trial);
      first <= 1'b0;
      qbit  <= ge && (den != '0);
    end
  end

endmodule

// ===== src/skf_mac.sv =====
// Two shift-and-add lanes fed by the quotient bits, most significant first.
// One lane forms K * diff, the other K * P1; the gain itself is collected too.
module skf_mac #(
  parameter int EW = 24,
  parameter int VW = 20,
  parameter int KW = 17
) (
  input  logic                        clk,
  input  skf_pkg::skf_ctl_t           ctl,
  input  logic                        qbit,
  input  logic signed [EW:0]          diff,
  input  logic [VW-1:0]               p1,
  output logic signed [EW+KW:0]       acc_e,
  output logic [VW+KW-1:0]            acc_v,
  output logic [KW-1:0]               gain_k
);
  import skf_pkg::*;

  localparam int AE = EW + KW + 1;
  localparam int AV = VW + KW;

  logic signed [EW:0] diff_q;
  logic [VW-1:0]      p1_q;

  // Operands are held for the whole run; accumulators double and add each step.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      diff_q <= diff;
      p1_q   <= p1;
      acc_e  <= '0;
      acc_v  <= '0;
      gain_k <= '0;
    end else if (ctl.mac_step) begin
      acc_e  <= (acc_e <<< 1) + (qbit ? AE'(diff_q) : AE'(0));
      acc_v  <= (acc_v << 1) + (qbit ? AV'(p1_q) : AV'(0));
      gain_k <= {gain_k[KW-2:0], qbit};
    end
  end

endmodule

// ===== src/scalar_kalman_filter.sv =====
// Channel    Direction  Width  Contents
// s_axis     in         16+1   tdata: sample; tuser: restart
// m_axis     out        40     tdata: filtered, gain
// cfg        in         2+20   cfg_index selects the register, cfg_wdata is the value
//
// An item passes the prepare, start, run, finish and done states after its
// acceptance before its result is registered. In the run state the divider makes
// one gain bit per cycle, and the multiply lanes fold each bit in the cycle after.
// A new item is accepted while a result still waits in the output register;
// the engine holds its last step until that register is free.
// Reset is synchronous and restores the registers, the estimate and the variance.
module scalar_kalman_filter #(
  parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // [15:0] sample
  input  logic                            s_axis_tuser,  // [0] restart
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [39:0]                     m_axis_tdata,  // [15:0] filtered, [32:16] gain
  input  logic                            cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [skf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import skf_pkg::*;

  localparam int VW = 4 + FRAC_BITS;
  localparam int EW = 8 + FRAC_BITS;
  localparam int KW = FRAC_BITS + 1;
  localparam int AE = EW + KW + 1;
  localparam int AV = VW + KW;
  localparam int CW = $clog2(KW + 1);

  localparam longint EST_RST_L = (longint'(98) << FRAC_BITS) / 10;
  localparam logic [EW-1:0] EST_RST = EW'(EST_RST_L);
  localparam logic [VW-1:0] EV_RST = VW'(longint'(1) << FRAC_BITS);
  localparam logic [VW-1:0] VAR_MAX = {VW{1'b1}};
  localparam logic signed [EW-1:0] EST_MAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic signed [EW-1:0] EST_MIN = {1'b1, {(EW-1){1'b0}}};
  localparam logic [AV-1:0] CEIL_ADD = AV'((longint'(1) << FRAC_BITS) - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_START,
    S_RUN,
    S_FIN,
    S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [19:0] meas_noise;
  logic [19:0] proc_noise;
  logic [15:0] init_est;
  logic [19:0] init_ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      meas_noise <= MEAS_NOISE_RST;
      proc_noise <= PROC_NOISE_RST;
      init_est   <= INIT_EST_RST;
      init_ev    <= INIT_EV_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MEAS_NOISE: meas_noise <= cfg_wdata;
        CFG_PROC_NOISE: proc_noise <= cfg_wdata;
        CFG_INIT_EST:   init_est   <= cfg_wdata[15:0];
        CFG_INIT_EV:    init_ev    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Register values brought to the internal formats.
  logic [VW-1:0]        r_var;
  logic [VW-1:0]        q_var;
  logic [VW-1:0]        ev_init;
  logic signed [EW-1:0] est_init;

  assign r_var    = VW'(var_scale(meas_noise, FRAC_BITS));
  assign q_var    = VW'(var_scale(proc_noise, FRAC_BITS));
  assign ev_init  = VW'(var_scale(init_ev, FRAC_BITS));
  assign est_init = EW'(signed'(init_est)) <<< (FRAC_BITS - 8);

  // Item and filter state.
  logic signed [15:0]   sample;
  logic                 restart;
  logic signed [EW-1:0] est;
  logic [VW-1:0]        ev;
  logic [VW-1:0]        p1;
  logic [VW-1:0]        kp_ceil;
  logic [CW-1:0]        cnt;

  // Prediction: pick the starting point, add the process noise, form the innovation.
  logic [VW-1:0]        ev_src;
  logic [VW:0]          p1_sum;
  logic signed [EW:0]   diff;
  logic signed [EW-1:0] z;

  assign ev_src = restart ? ev_init : ev;
  assign p1_sum = {1'b0, ev_src} + {1'b0, q_var};
  assign z      = EW'(sample) <<< (FRAC_BITS - 8);
  assign diff   = (EW+1)'(z) - (EW+1)'(est);

  // Update: add the scaled innovation, then clamp.
  logic signed [AE-1:0] acc_e;
  logic [AV-1:0]        acc_v;
  logic [KW-1:0]        gain_k;
  logic signed [AE:0]   est_sum;
  logic signed [EW-1:0] est_clamped;

  assign est_sum = (AE+1)'(est) + (AE+1)'(acc_e >>> FRAC_BITS);

  always_comb begin
    if (est_sum > (AE+1)'(EST_MAX)) begin
      est_clamped = EST_MAX;
    end else if (est_sum < (AE+1)'(EST_MIN)) begin
      est_clamped = EST_MIN;
    end else begin
      est_clamped = EW'(est_sum);
    end
  end

  // Strobes for the divider and the multiply lanes.
  skf_ctl_t ctl;
  logic     qbit;

  always_comb begin
    ctl.start    = (state == S_START);
    ctl.div_step = (state == S_RUN) && (cnt < CW'(KW));
    ctl.mac_step = (state == S_RUN) && (cnt != '0);
  end

  skf_div #(
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .ctl      (ctl),
    .p1       (p1),
    .meas_var (r_var),
    .qbit     (qbit)
  );

  skf_mac #(
    .EW (EW),
    .VW (VW),
    .KW (KW)
  ) u_mac (
    .clk    (clk),
    .ctl    (ctl),
    .qbit   (qbit),
    .diff   (diff),
    .p1     (p1),
    .acc_e  (acc_e),
    .acc_v  (acc_v),
    .gain_k (gain_k)
  );

  assign s_axis_tready = (state == S_IDLE);

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Sequencer, filter state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      est           <= EST_RST;
      ev            <= EV_RST;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // A taken result leaves unless the engine refills the register now.
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            sample  <= s_axis_tdata;
            restart <= s_axis_tuser;
            state   <= S_PREP;
          end
        end
        S_PREP: begin
          if (restart) begin
            est <= est_init;
          end
          p1    <= p1_sum[VW] ? VAR_MAX : p1_sum[VW-1:0];
          state <= S_START;
        end
        S_START: begin
          cnt   <= '0;
          state <= S_RUN;
        end
        S_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(KW)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          est     <= est_clamped;
          kp_ceil <= VW'((acc_v + CEIL_ADD) >> FRAC_BITS);
          state   <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            ev            <= p1 - kp_ceil;
            m_axis_tdata  <= {7'd0, gain_scale(25'(gain_k), FRAC_BITS),
                              est[EW-1:FRAC_BITS-8]};
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== verif/scalar_kalman_filter_checker.sv =====
`timescale 1ns / 100ps

// Watches the sample, result and configuration channels of the filter, keeps
// its own copy of the filter state and compares every result with the
// prediction for the oldest sample still in flight.
module scalar_kalman_filter_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,  // [15:0] sample
  input  logic                           s_axis_tuser,  // [0] restart
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [39:0]                    m_axis_tdata,  // [15:0] filtered, [32:16] gain
  input  logic                           cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [skf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                    fail_count,
  output int unsigned                    outstanding
);

  import skf_pkg::*;

  localparam int     FB      = FRAC_BITS_DEF;
  localparam longint VAR_TOP = (longint'(1) << (4 + FB)) - 1;
  localparam longint EST_TOP = (longint'(1) << (7 + FB)) - 1;
  localparam longint EST_BOT = -EST_TOP - 1;
  localparam longint UNITY   = longint'(1) << FB;

  typedef struct packed {
    logic [15:0] filtered;
    logic [16:0] gain;
  } kf_result_t;

  // Register copies and filter state.
  logic [19:0] meas_noise_reg;
  logic [19:0] proc_noise_reg;
  logic [15:0] init_est_reg;
  logic [19:0] init_ev_reg;
  longint      est_acc;
  longint      err_var;

  kf_result_t  pending_results[$];
  int unsigned mismatches = 0;

  // Rescale a Q4.16 register value to the internal variance format.
  function automatic longint var_from_q16(input logic [19:0] v);
    longint r;
    r = longint'(v);
    return (FB >= 16) ? (r << (FB - 16)) : (r >> (16 - FB));
  endfunction

  function automatic longint clip(input longint x, input longint lo, input longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // One filter update: predict the variance, form the gain, correct the
  // estimate and shrink the variance. Arithmetic right shifts floor.
  function automatic kf_result_t kalman_update(input logic [15:0] smp, input logic rs);
    kf_result_t res;
    longint     z;
    longint     p1;
    longint     den;
    longint     k;
    longint     diff;
    z = longint'($signed(smp)) <<< (FB - 8);
    if (rs) begin
      est_acc = longint'($signed(init_est_reg)) <<< (FB - 8);
      err_var = var_from_q16(init_ev_reg);
    end
    p1 = err_var + var_from_q16(proc_noise_reg);
    if (p1 > VAR_TOP) p1 = VAR_TOP;
    den = p1 + var_from_q16(meas_noise_reg);
    k = (den == 0) ? 0 : (p1 <<< FB) / den;
    diff = z - est_acc;
    est_acc = clip(est_acc + ((k * diff) >>> FB), EST_BOT, EST_TOP);
    err_var = clip(((UNITY - k) * p1) >>> FB, 0, VAR_TOP);
    res.filtered = 16'(est_acc >>> (FB - 8));
    res.gain = (FB >= 16) ? 17'(k >> (FB - 16)) : 17'(k << (16 - FB));
    return res;
  endfunction

  // Track resets, register writes, accepted samples and accepted results.
  always @(posedge clk) begin
    kf_result_t got;
    kf_result_t want;
    if (rst) begin
      meas_noise_reg = MEAS_NOISE_RST;
      proc_noise_reg = PROC_NOISE_RST;
      init_est_reg   = INIT_EST_RST;
      init_ev_reg    = INIT_EV_RST;
      est_acc        = (longint'(98) << FB) / 10;
      err_var        = UNITY;
      pending_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.filtered = m_axis_tdata[15:0];
        got.gain     = m_axis_tdata[32:16];
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected: filtered %h gain %h",
                   $time, got.filtered, got.gain);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got.filtered !== want.filtered) begin
            $display("%0t: filtered mismatch: expected %h, actual %h",
                     $time, want.filtered, got.filtered);
            mismatches++;
          end
          if (got.gain !== want.gain) begin
            $display("%0t: gain mismatch: expected %h, actual %h",
                     $time, want.gain, got.gain);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(kalman_update(s_axis_tdata, s_axis_tuser));
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MEAS_NOISE: meas_noise_reg = cfg_wdata;
          CFG_PROC_NOISE: proc_noise_reg = cfg_wdata;
          CFG_INIT_EST:   init_est_reg   = cfg_wdata[15:0];
          CFG_INIT_EV:    init_ev_reg    = cfg_wdata;
          default: ;
        endcase
      end
    end
    outstanding <= pending_results.size();
    fail_count  <= mismatches;
  end

endmodule

// ===== verif/scalar_kalman_filter_test.sv =====
`timescale 1ns / 100ps

module scalar_kalman_filter_test;

  import skf_pkg::*;

  localparam int HOLD_LEN    = 400;
  localparam int PHASE_ITEMS = 142;
  localparam int NUM_PHASES  = 8;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata;  // [15:0] sample
  logic                  s_axis_tuser;  // [0] restart
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [39:0]           m_axis_tdata;  // [15:0] filtered, [32:16] gain
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned fail_count;
  int unsigned outstanding;
  int          idle_pct = 0;
  int          stall_pct;
  logic        hold_off_req;
  int          hold_cycles = 0;

  scalar_kalman_filter i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  scalar_kalman_filter_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  always #10 clk = ~clk;

  // Result side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_off_req && hold_cycles < HOLD_LEN) begin
      hold_cycles <= hold_cycles + 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (!hold_off_req) hold_cycles <= 0;
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one sample, with random idle cycles first, and wait for acceptance.
  task automatic send_sample(input logic [15:0] smp, input logic rs);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= rs;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Stop offering and wait until every expected result has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (FRAC_BITS_DEF + 10) @(posedge clk);
  endtask

  // Write all four filter registers on consecutive cycles.
  task automatic program_filter(input logic [19:0] r, input logic [19:0] q,
                                input logic [15:0] ie, input logic [19:0] iev);
    cfg_idx_t    idx[4];
    logic [19:0] vals[4];
    idx  = '{CFG_MEAS_NOISE, CFG_PROC_NOISE, CFG_INIT_EST, CFG_INIT_EV};
    vals = '{r, q, {4'($urandom), ie}, iev};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Noise variances biased toward zero, full scale and small values.
  function automatic logic [19:0] pick_variance();
    case ($urandom_range(5))
      0:       return 20'h0;
      1:       return 20'hFFFFF;
      2:       return 20'($urandom_range(0, 255));
      3:       return 20'($urandom_range(0, 20'h1FFFF));
      default: return 20'($urandom);
    endcase
  endfunction

  initial begin
    int          level;
    int          v;
    int          sel;
    logic [15:0] smp;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_MEAS_NOISE;
    cfg_wdata     <= '0;
    stall_pct     <= 0;
    hold_off_req  <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: start from the reset estimate, extremes, restart to the
    // register value, zero denominator, variance saturation, unity and tiny gain.
    send_sample(16'h0000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h0A00, 1'b1);
    wait_drained();
    program_filter(20'h0, 20'h0, 16'h0000, 20'h0);
    send_sample(16'h1234, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    wait_drained();
    program_filter(20'h0, 20'hFFFFF, 16'h7FFF, 20'hFFFFF);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h5555, 1'b0);
    wait_drained();
    program_filter(20'hFFFFF, 20'h0, 16'h8000, 20'h1);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h0000, 1'b0);
    wait_drained();
    program_filter(20'h0, 20'h0, 16'hFF00, 20'h5);
    send_sample(16'h0100, 1'b1);
    send_sample(16'hFEFF, 1'b0);
    wait_drained();

    // Random phases, each with its own settings; four idle/stall patterns rotate.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 70; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 70; end
        default: begin idle_pct = 35; stall_pct <= 35; end
      endcase
      if (ph == 0) begin
        program_filter(MEAS_NOISE_RST, PROC_NOISE_RST, INIT_EST_RST, INIT_EV_RST);
      end else begin
        program_filter(pick_variance(), pick_variance(), 16'($urandom), pick_variance());
      end
      // Hold the result side off so the block fills up and stalls its input.
      if (ph == 4) hold_off_req <= 1'b1;
      level = int'($urandom_range(0, 65535)) - 32768;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(49) == 0) level = int'($urandom_range(0, 65535)) - 32768;
        sel = $urandom_range(99);
        if (sel < 60) begin
          // Steady reading with sensor noise on top.
          v = level + int'($urandom_range(0, 2047)) - 1024;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          smp = 16'(v);
        end else if (sel < 85) begin
          smp = 16'($urandom);
        end else begin
          case ($urandom_range(2))
            0:       smp = 16'h7FFF;
            1:       smp = 16'h8000;
            default: smp = 16'h0000;
          endcase
        end
        send_sample(smp, ($urandom_range(19) == 0));
      end
      hold_off_req <= 1'b0;
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("** scalar_kalman_filter: PASSED **");
    end else begin
      $display("** scalar_kalman_filter: FAILED **");
    end
    $finish;
  end

  // Give up if the run hangs.
  initial begin
    #20ms;
    $display("** scalar_kalman_filter: FAILED **");
    $finish;
  end

endmodule
